// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 16;

   localparam int ADDR_W      = 32;
   localparam int OP_W        = 2;
   localparam int ST_W        = 2;
   localparam int ENTRY_W     = 2 * ADDR_W + 1;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;

   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_NULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_OOM     = 2'd2;
   localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_DECIDE   = 6'b000100,
      S_WR_ALLOC = 6'b001000,
      S_WR_FREE  = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic decide;
      logic wr_alloc;
      logic wr_free;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Allocate, free and resize requests against an address-ordered block table.
// ----------------------------------------------------------------------------
// One request is handled at a time: the controller scans the table, decides,
// writes the table and loads the result register. The scan reads one table
// entry per cycle from the single read port of the block table RAM. A result
// waits in its output register while the next item is taken in.
module first_fit_heap_allocator_unit #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // op [1:0], req_size [33:2], user_addr [65:34], zeros above
   input  logic [ffha_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_addr [31:0], copy_len [63:32], status [65:64], zeros above
   output logic [ffha_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ffha_pkg::ADDR_W-1:0]         csr_wr_data
);

   ffha_pkg::ctl_cmd_type   cmd;
   ffha_pkg::dp_status_type status;
   logic [ffha_pkg::ADDR_W-1:0] rsp_addr, rsp_copy;
   logic [ffha_pkg::ST_W-1:0]   rsp_status;

   ffha_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ffha_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_tdata[1:0]),
      .req_size    (req_tdata[33:2]),
      .req_addr    (req_tdata[65:34]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_addr    (rsp_addr),
      .rsp_copy    (rsp_copy),
      .rsp_status  (rsp_status)
   );

   assign rsp_tdata = {6'b0, rsp_status, rsp_copy, rsp_addr};

endmodule

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ffha_datapath.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Block table, scan for address match and first fit, and the update plan.
// ----------------------------------------------------------------------------
module ffha_datapath #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ffha_pkg::ctl_cmd_type          cmd,
   output ffha_pkg::dp_status_type        status,
   input  logic [ffha_pkg::OP_W-1:0]      req_op,
   input  logic [ffha_pkg::ADDR_W-1:0]    req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]    req_addr,
   input  logic                           csr_wr_en,
   input  logic [ffha_pkg::ADDR_W-1:0]    csr_wr_data,
   output logic [ffha_pkg::ADDR_W-1:0]    rsp_addr,
   output logic [ffha_pkg::ADDR_W-1:0]    rsp_copy,
   output logic [ffha_pkg::ST_W-1:0]      rsp_status
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int AW    = ffha_pkg::ADDR_W;
   localparam int EW    = ffha_pkg::ENTRY_W;
   localparam logic [AW:0]   HDR33 = (AW + 1)'(HEADER_BYTES);
   localparam logic [AW+1:0] HDR34 = (AW + 2)'(HEADER_BYTES);
   localparam logic [AW-1:0] HDR32 = AW'(HEADER_BYTES);

   logic [ffha_pkg::OP_W-1:0] op_ff;
   logic [AW-1:0] size_ff, addr_ff, heap_limit_ff, break_ff;
   logic [CNT_W-1:0] count_ff, rd_cnt_ff;
   logic ev_valid_ff;
   logic find_hit_ff, fit_hit_ff;
   logic [IDX_W-1:0] find_idx_ff, fit_idx_ff;
   logic [AW-1:0] find_start_ff, find_size_ff, fit_start_ff, fit_size_ff;
   logic wa_en_ff, wf_en_ff;
   logic [IDX_W-1:0] wa_idx_ff, wf_idx_ff;
   logic [EW-1:0] wa_data_ff, wf_data_ff;
   logic [AW-1:0] res_ff, copy_ff, rsp_addr_ff, rsp_copy_ff;
   logic [ffha_pkg::ST_W-1:0] st_ff, rsp_status_ff;

   logic issue;
   logic [EW-1:0] rd_data;
   logic ev_match, ev_fit;
   logic [IDX_W-1:0] ev_idx;
   logic ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;

   logic [AW+1:0] end_w;
   logic can_append, a_null, a_reuse, a_app, a_ok;
   logic [AW-1:0] a_addr;
   logic [ffha_pkg::ST_W-1:0] a_st;
   logic do_alloc, do_free, last;
   logic [AW-1:0] res_in, copy_in, break_a, break_in;
   logic [ffha_pkg::ST_W-1:0] st_in;
   logic [CNT_W-1:0] count_a, count_in;

   assign issue = cmd.scan && (rd_cnt_ff < count_ff);
   assign status.scan_done = !ev_valid_ff && (rd_cnt_ff >= count_ff);

   assign ram_wr_en   = (cmd.wr_alloc && wa_en_ff) || (cmd.wr_free && wf_en_ff);
   assign ram_wr_addr = cmd.wr_alloc ? wa_idx_ff : wf_idx_ff;
   assign ram_wr_data = cmd.wr_alloc ? wa_data_ff : wf_data_ff;

   ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // The entry being evaluated was read from the previous read address.
   assign ev_idx = rd_cnt_ff[IDX_W-1:0] - IDX_W'(1);

   // Entry layout: free mark on top, then size, then start.
   assign ev_match = ({1'b0, rd_data[AW-1:0]} + HDR33) == {1'b0, addr_ff};
   assign ev_fit   = rd_data[EW-1] && (rd_data[2*AW-1:AW] >= size_ff);

   always_comb begin
      end_w      = {2'b00, break_ff} + HDR34 + {2'b00, size_ff};
      can_append = (count_ff < CNT_W'(MAX_BLOCKS)) && (end_w <= {2'b00, heap_limit_ff});
      a_null     = (size_ff == '0);
      a_reuse    = !a_null && fit_hit_ff;
      a_app      = !a_null && !fit_hit_ff && can_append;
      a_ok       = a_reuse || a_app;
      a_addr     = a_reuse ? (fit_start_ff + HDR32) : (break_ff + HDR32);
      a_st       = a_null ? ffha_pkg::ST_NULL : (a_ok ? ffha_pkg::ST_OK : ffha_pkg::ST_OOM);

      do_alloc = 1'b0;
      do_free  = 1'b0;
      res_in   = '0;
      copy_in  = '0;
      st_in    = ffha_pkg::ST_NULL;
      case (op_ff)
         ffha_pkg::OP_ALLOC: begin
            do_alloc = 1'b1;
            res_in   = a_ok ? a_addr : '0;
            st_in    = a_st;
         end
         ffha_pkg::OP_FREE: begin
            if (addr_ff == '0) begin
               st_in = ffha_pkg::ST_NULL;
            end else if (!find_hit_ff) begin
               st_in = ffha_pkg::ST_UNKNOWN;
            end else begin
               do_free = 1'b1;
               st_in   = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::OP_RESIZE: begin
            if (addr_ff == '0 || size_ff == '0) begin
               do_alloc = 1'b1;
               res_in   = a_ok ? a_addr : '0;
               st_in    = a_st;
            end else if (!find_hit_ff) begin
               st_in = ffha_pkg::ST_UNKNOWN;
            end else if (find_size_ff >= size_ff) begin
               res_in = addr_ff;
               st_in  = ffha_pkg::ST_OK;
            end else begin
               do_alloc = 1'b1;
               res_in   = a_ok ? a_addr : '0;
               st_in    = a_st;
               if (a_ok) begin
                  copy_in = find_size_ff;
                  do_free = 1'b1;
               end
            end
         end
         default: begin
            st_in = ffha_pkg::ST_NULL;
         end
      endcase

      count_a  = (do_alloc && a_app) ? count_ff + CNT_W'(1) : count_ff;
      break_a  = (do_alloc && a_app) ? end_w[AW-1:0] : break_ff;
      last     = (CNT_W'(find_idx_ff) + CNT_W'(1)) == count_a;
      count_in = (do_free && last) ? count_a - CNT_W'(1) : count_a;
      break_in = (do_free && last) ? find_start_ff : break_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= ffha_pkg::HEAP_LIMIT_RESET;
         count_ff      <= '0;
         break_ff      <= '0;
         ev_valid_ff   <= 1'b0;
         wa_en_ff      <= 1'b0;
         wf_en_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            heap_limit_ff <= csr_wr_data;
         end
         if (cmd.start) begin
            op_ff       <= req_op;
            size_ff     <= req_size;
            addr_ff     <= req_addr;
            rd_cnt_ff   <= '0;
            ev_valid_ff <= 1'b0;
            find_hit_ff <= 1'b0;
            fit_hit_ff  <= 1'b0;
         end else if (cmd.scan) begin
            ev_valid_ff <= issue;
            if (issue) begin
               rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
            end
         end
         if (ev_valid_ff && ev_match && !find_hit_ff) begin
            find_hit_ff   <= 1'b1;
            find_idx_ff   <= ev_idx;
            find_start_ff <= rd_data[AW-1:0];
            find_size_ff  <= rd_data[2*AW-1:AW];
         end
         if (ev_valid_ff && ev_fit && !fit_hit_ff) begin
            fit_hit_ff   <= 1'b1;
            fit_idx_ff   <= ev_idx;
            fit_start_ff <= rd_data[AW-1:0];
            fit_size_ff  <= rd_data[2*AW-1:AW];
         end
         if (cmd.decide) begin
            count_ff   <= count_in;
            break_ff   <= break_in;
            res_ff     <= res_in;
            copy_ff    <= copy_in;
            st_ff      <= st_in;
            wa_en_ff   <= do_alloc && a_ok;
            wa_idx_ff  <= a_reuse ? fit_idx_ff : count_ff[IDX_W-1:0];
            wa_data_ff <= a_reuse ? {1'b0, fit_size_ff, fit_start_ff}
                                  : {1'b0, size_ff, break_ff};
            wf_en_ff   <= do_free && !last;
            wf_idx_ff  <= find_idx_ff;
            wf_data_ff <= {1'b1, find_size_ff, find_start_ff};
         end
         if (cmd.load_rsp) begin
            rsp_addr_ff   <= res_ff;
            rsp_copy_ff   <= copy_ff;
            rsp_status_ff <= st_ff;
         end
      end
   end

   assign rsp_addr   = rsp_addr_ff;
   assign rsp_copy   = rsp_copy_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/ffha_controller.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences scan, decision, table writes and the result register.
// ----------------------------------------------------------------------------
module ffha_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  ffha_pkg::dp_status_type status,
   output ffha_pkg::ctl_cmd_type   cmd
);

   ffha_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ffha_pkg::S_SCAN;
            end
         end
         ffha_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ffha_pkg::S_DECIDE;
            end
         end
         ffha_pkg::S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ffha_pkg::S_WR_ALLOC;
         end
         ffha_pkg::S_WR_ALLOC: begin
            cmd.wr_alloc = 1'b1;
            state_in     = ffha_pkg::S_WR_FREE;
         end
         ffha_pkg::S_WR_FREE: begin
            cmd.wr_free = 1'b1;
            state_in    = ffha_pkg::S_RESP;
         end
         ffha_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ffha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ffha_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ffha_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result item changed while stalled.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second item taken while one is in progress.");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[65:64] != ffha_pkg::ST_OK) |-> rsp_tdata[31:0] == '0)
      else $error("Failed request returned an address.");

   a_copy_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[63:32] != '0) |->
         (rsp_tdata[65:64] == ffha_pkg::ST_OK) && (rsp_tdata[31:0] != '0))
      else $error("Copy length given without a successful move.");

endmodule

bind first_fit_heap_allocator_unit ffha_port_checker u_ffha_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Watches the request and response streams, keeps its own block table and
// break pointer, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module ffha_checker
   import ffha_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [ADDR_W-1:0]      csr_wr_data,
   output int                     fail_count,
   output int                     pending_count,
   output logic [6:0]             block_count,
   output logic [ADDR_W-1:0]      heap_break
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] copy;
      logic [ST_W-1:0]   status;
   } alloc_reply_t;

   logic [ADDR_W-1:0] blk_start [MAX_BLOCKS_DEF];
   logic [ADDR_W-1:0] blk_size [MAX_BLOCKS_DEF];
   logic              blk_free [MAX_BLOCKS_DEF];
   logic [ADDR_W-1:0] limit_q;
   alloc_reply_t      replies_due [$];

   function automatic int lookup_block(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < block_count; i++)
         if ({1'b0, blk_start[i]} + HEADER_BYTES_DEF == {1'b0, addr})
            return i;
      return -1;
   endfunction

   function automatic logic [ADDR_W-1:0] grab_block(logic [ADDR_W-1:0] size,
                                                     output logic [ST_W-1:0] st);
      logic [ADDR_W+1:0] top;
      if (size == 0) begin
         st = ST_NULL;
         return '0;
      end
      for (int i = 0; i < block_count; i++)
         if (blk_free[i] && blk_size[i] >= size) begin
            blk_free[i] = 1'b0;
            st = ST_OK;
            return blk_start[i] + HEADER_BYTES_DEF;
         end
      top = {2'b0, heap_break} + HEADER_BYTES_DEF + {2'b0, size};
      if (block_count >= MAX_BLOCKS_DEF || top > {2'b0, limit_q}) begin
         st = ST_OOM;
         return '0;
      end
      blk_start[block_count] = heap_break;
      blk_size[block_count] = size;
      blk_free[block_count] = 1'b0;
      block_count = block_count + 1;
      heap_break = top[ADDR_W-1:0];
      st = ST_OK;
      return heap_break - size;
   endfunction

   function automatic void release_block(int i);
      if (i + 1 == block_count) begin
         heap_break = blk_start[i];
         block_count = block_count - 1;
      end else begin
         blk_free[i] = 1'b1;
      end
   endfunction

   function automatic alloc_reply_t serve_request(logic [REQ_TDATA_W-1:0] d);
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] size, addr, old_size;
      alloc_reply_t      r;
      int                idx;
      op = d[1:0];
      size = d[33:2];
      addr = d[65:34];
      r = '{addr: '0, copy: '0, status: ST_NULL};
      if (op == OP_ALLOC) begin
         r.addr = grab_block(size, r.status);
      end else if (op == OP_FREE) begin
         if (addr != 0) begin
            idx = lookup_block(addr);
            if (idx < 0) r.status = ST_UNKNOWN;
            else begin
               release_block(idx);
               r.status = ST_OK;
            end
         end
      end else if (op == OP_RESIZE) begin
         if (addr == 0 || size == 0) begin
            r.addr = grab_block(size, r.status);
         end else begin
            idx = lookup_block(addr);
            if (idx < 0) r.status = ST_UNKNOWN;
            else if (blk_size[idx] >= size) begin
               r.addr = addr;
               r.status = ST_OK;
            end else begin
               old_size = blk_size[idx];
               r.addr = grab_block(size, r.status);
               if (r.addr != 0) begin
                  r.copy = old_size;
                  release_block(idx);
               end
            end
         end
      end
      return r;
   endfunction

   assign pending_count = replies_due.size();

   always @(posedge clock) begin
      alloc_reply_t want;
      if (reset) begin
         block_count <= '0;
         heap_break <= '0;
         limit_q <= HEAP_LIMIT_RESET;
         fail_count <= 0;
         replies_due.delete();
      end else begin
         if (csr_wr_en) limit_q <= csr_wr_data;
         if (req_tvalid && req_tready)
            replies_due.push_back(serve_request(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $error("response with nothing outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = replies_due.pop_front();
               if (rsp_tdata[31:0] !== want.addr) begin
                  $error("result_addr expected %h got %h", want.addr, rsp_tdata[31:0]);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tdata[63:32] !== want.copy) begin
                  $error("copy_len expected %h got %h", want.copy, rsp_tdata[63:32]);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tdata[65:64] !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_tdata[65:64]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Directed and random allocate, free and resize traffic under several heap
// limits, with random idling on both streams and one long response stall.
// ----------------------------------------------------------------------------
module tb;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ffha_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ffha_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_wr_en = 1'b0;
   logic [ffha_pkg::ADDR_W-1:0]      csr_wr_data = '0;
   int                               fail_count, pending_count;
   logic [6:0]                       block_count;
   logic [ffha_pkg::ADDR_W-1:0]      heap_break;
   logic [ffha_pkg::ADDR_W-1:0]      live_addrs [$];
   bit                               calm = 1'b0;
   bit                               hold_rsp = 1'b0;

   always #1 clock = ~clock;

   first_fit_heap_allocator_unit u_top (.*);

   ffha_checker u_chk (.*);

   initial begin
      #3000000;
      $display("first_fit_heap_allocator_unit regression: fail");
      $finish;
   end

   // Collects returned addresses so that frees and resizes hit real blocks.
   always @(posedge clock)
      if (rsp_tvalid && rsp_tready && rsp_tdata[31:0] != 0 && live_addrs.size() < 200)
         live_addrs.push_back(rsp_tdata[31:0]);

   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_item(logic [ffha_pkg::OP_W-1:0] op, logic [ffha_pkg::ADDR_W-1:0] size,
                            logic [ffha_pkg::ADDR_W-1:0] addr);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, addr, size, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_and_set(logic [ffha_pkg::ADDR_W-1:0] limit);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_addrs.delete();
   endtask

   function automatic logic [ffha_pkg::ADDR_W-1:0] pick_addr();
      if (live_addrs.size() != 0 && $urandom_range(0, 9) != 0)
         return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      if ($urandom_range(0, 3) == 0) return '0;
      return $urandom;
   endfunction

   function automatic logic [ffha_pkg::ADDR_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   initial begin
      logic [ffha_pkg::OP_W-1:0] op;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: zero size, null free, unknown address, repeat free,
      // resize cases, unused op, then an exhausted table.
      send_item(ffha_pkg::OP_ALLOC, 0, 0);
      send_item(ffha_pkg::OP_FREE, 0, 0);
      send_item(ffha_pkg::OP_FREE, 0, 32'hFFFF_FFFF);
      send_item(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0);
      send_item(ffha_pkg::OP_ALLOC, 100, 0);
      send_item(ffha_pkg::OP_ALLOC, 50, 0);
      send_item(ffha_pkg::OP_FREE, 0, 16);
      send_item(ffha_pkg::OP_FREE, 0, 16);
      send_item(ffha_pkg::OP_ALLOC, 80, 0);
      send_item(ffha_pkg::OP_RESIZE, 10, 16);
      send_item(ffha_pkg::OP_RESIZE, 0, 16);
      send_item(ffha_pkg::OP_RESIZE, 20, 0);
      send_item(ffha_pkg::OP_RESIZE, 500, 16);
      send_item(ffha_pkg::OP_RESIZE, 32'h7FFF_FFFF, 16);
      send_item(ffha_pkg::OP_RESIZE, 5, 32'h1234_5670);
      send_item(ffha_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ffha_pkg::OP_FREE, 0, 148);
      drain_and_set(32'hFFFF_FFFF);
      repeat (66) send_item(ffha_pkg::OP_ALLOC, 1, 0);
      drain_and_set(0);
      send_item(ffha_pkg::OP_ALLOC, 1, 0);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               drain_and_set(32'd4000);
               hold_rsp = 1'b1;
            end
            1: drain_and_set(ffha_pkg::HEAP_LIMIT_RESET);
            2: drain_and_set(32'hFFFF_FFFF);
            default: begin
               drain_and_set(32'd20000);
               calm = 1'b1;
            end
         endcase
         for (int n = 0; n < 270; n++) begin
            op = $urandom_range(0, 9) < 4 ? ffha_pkg::OP_ALLOC :
                 ($urandom_range(0, 1) ? ffha_pkg::OP_FREE :
                 ($urandom_range(0, 20) == 0 ? ffha_pkg::OP_UNUSED : ffha_pkg::OP_RESIZE));
            send_item(op, pick_size(), pick_addr());
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("first_fit_heap_allocator_unit regression: pass");
      else
         $display("first_fit_heap_allocator_unit regression: fail");
      $finish;
   end

endmodule
